### design/point_in_polygon_test_assert.svh
// Assertion macros shared by the point-in-polygon design files.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef POINT_IN_POLYGON_TEST_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_ASSERT_SVH

// Condition holds at every clock edge outside reset
`define PIP_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle
`define PIP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle
`define PIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/pip_pkg.sv
// Shared types and constants for the point-in-polygon block.
// No dependencies; used by the front, queue, back and top level.
`default_nettype none

package pip_pkg;

    // Coordinate format: signed fixed point, 18 bits
    localparam int COORD_W   = 18;
    // Fraction bits of the coordinate format (1.0 = 2^FRAC_BITS)
    localparam int FRAC_BITS = 16;
    // Coordinates relative to the query point
    localparam int REL_W   = COORD_W + 1;
    // Cross products of relative coordinates
    localparam int PROD_W  = 2 * REL_W;
    // Squares and their sum for the disk test
    localparam int SQ_W    = 2 * COORD_W;
    localparam int SUM_W   = SQ_W + 1;
    // Depth of the command queue between front and back
    localparam int Q_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // Classified command handed from front to back
    typedef struct packed {
        op_t                        op;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic                       outside;
    } cmd_t;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic nonempty;
    } q_stat_t;

endpackage

`default_nettype wire

### design/pip_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pip_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### design/pip_front.sv
// Front end: takes input beats, squares the coordinates and flags points
// outside the unit disk. Depends on pip_pkg.
`default_nettype none

module pip_front (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [1:0]                           opcode,
    input  wire logic signed [pip_pkg::COORD_W-1:0]   point_x,
    input  wire logic signed [pip_pkg::COORD_W-1:0]   point_y,
    input  wire pip_pkg::q_stat_t                     q_stat,
    output logic                                      push,
    output pip_pkg::cmd_t                             push_cmd
);

    // 1.0 squared in the format of the squares (2*FRAC_BITS fraction bits)
    localparam logic [63:0] ONE_SQ = 64'd1 << (2 * pip_pkg::FRAC_BITS);

    logic                                 s0_vld_reg;
    pip_pkg::op_t                         s0_op_reg;
    logic signed [pip_pkg::COORD_W-1:0]   s0_x_reg;
    logic signed [pip_pkg::COORD_W-1:0]   s0_y_reg;

    logic                                 s1_vld_reg;
    pip_pkg::op_t                         s1_op_reg;
    logic signed [pip_pkg::COORD_W-1:0]   s1_x_reg;
    logic signed [pip_pkg::COORD_W-1:0]   s1_y_reg;
    logic [pip_pkg::SQ_W-1:0]             s1_sqx_reg;
    logic [pip_pkg::SQ_W-1:0]             s1_sqy_reg;

    logic signed [pip_pkg::SQ_W-1:0]      sqx_next;
    logic signed [pip_pkg::SQ_W-1:0]      sqy_next;
    logic [pip_pkg::SUM_W-1:0]            sum;
    logic                                 s1_free;
    logic                                 s0_move;

    // Stage handshake
    assign s1_free  = !s1_vld_reg || !q_stat.full;
    assign s0_move  = s0_vld_reg && s1_free;
    assign in_stall = s0_vld_reg && !s1_free;
    assign push     = s1_vld_reg && !q_stat.full;

    // Squares of the point coordinates
    assign sqx_next = s0_x_reg * s0_x_reg;
    assign sqy_next = s0_y_reg * s0_y_reg;

    // Disk test on the registered squares
    assign sum = {1'b0, s1_sqx_reg} + {1'b0, s1_sqy_reg};

    always_comb
    begin
        push_cmd.op      = s1_op_reg;
        push_cmd.x       = s1_x_reg;
        push_cmd.y       = s1_y_reg;
        push_cmd.outside = 64'(sum) > ONE_SQ;
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                s0_vld_reg <= 1'b1;
            end
            else if (s0_move)
            begin
                s0_vld_reg <= 1'b0;
            end
            if (s1_free)
            begin
                s1_vld_reg <= s0_move;
            end
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s0_op_reg <= pip_pkg::op_t'(opcode);
            s0_x_reg  <= point_x;
            s0_y_reg  <= point_y;
        end
        if (s0_move)
        begin
            s1_op_reg  <= s0_op_reg;
            s1_x_reg   <= s0_x_reg;
            s1_y_reg   <= s0_y_reg;
            s1_sqx_reg <= sqx_next;
            s1_sqy_reg <= sqy_next;
        end
    end

endmodule

`default_nettype wire

### design/pip_queue.sv
// Short command queue between the front end and the back end.
// Depends on pip_pkg and the assertion macro header.
`default_nettype none
`include "point_in_polygon_test_assert.svh"

module pip_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire pip_pkg::cmd_t    push_cmd,
    input  wire logic             pop,
    output pip_pkg::cmd_t         head_cmd,
    output pip_pkg::q_stat_t      q_stat
);

    localparam int QAW = $clog2(pip_pkg::Q_DEPTH);
    localparam int QCW = $clog2(pip_pkg::Q_DEPTH + 1);

    pip_pkg::cmd_t     entry_reg [pip_pkg::Q_DEPTH];
    logic [QAW-1:0]    wr_ptr_reg;
    logic [QAW-1:0]    rd_ptr_reg;
    logic [QCW-1:0]    cnt_reg;
    logic              push_ok;
    logic              pop_ok;

    assign q_stat.full     = cnt_reg == QCW'(pip_pkg::Q_DEPTH);
    assign q_stat.nonempty = cnt_reg != '0;
    assign push_ok         = push && !q_stat.full;
    assign pop_ok          = pop && q_stat.nonempty;
    assign head_cmd        = entry_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push_ok && !pop_ok)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop_ok && !push_ok)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `PIP_ASSERT_NEXT(a_q_fill, push_ok && !pop_ok, cnt_reg == $past(cnt_reg) + 1'b1, "queue fill level did not rise on push")

endmodule

`default_nettype wire

### design/pip_back.sv
// Back end: executes queued commands, keeps the vertex table and walks the
// polygon edges for queries. Depends on pip_pkg, pip_ram and the macro header.
`default_nettype none
`include "point_in_polygon_test_assert.svh"

module pip_back #(
    parameter int MAX_VERTICES = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire pip_pkg::q_stat_t                       q_stat,
    input  wire pip_pkg::cmd_t                          q_cmd,
    output logic                                        pop,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic                                        inside_res,
    output logic [$clog2(MAX_VERTICES+1)-1:0]           vertex_count,
    output logic [1:0]                                  status
);

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int CW    = pip_pkg::COORD_W;
    localparam int RW    = pip_pkg::REL_W;
    localparam int PW    = pip_pkg::PROD_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

    // Control state and output register
    state_t             state_reg,      state_next;
    logic [CNT_W-1:0]   count_reg,      count_next;
    logic               out_valid_reg,  out_valid_next;
    logic               out_inside_reg, out_inside_next;
    logic [CNT_W-1:0]   out_count_reg,  out_count_next;
    pip_pkg::status_t   out_status_reg, out_status_next;

    logic               out_free;
    logic               walk_start;
    logic               we;

    // Read issue
    logic               issuing_reg;
    logic [CNT_W-1:0]   rd_idx_reg;
    logic               rd_wrap;
    logic [AW-1:0]      raddr;
    logic [2*CW-1:0]    rdata;

    // Query point
    logic signed [CW-1:0] px_reg;
    logic signed [CW-1:0] py_reg;

    // Read data stage flags
    logic               rd_vld_reg;
    logic               rd_first_reg;
    logic               rd_last_reg;

    // Relative vertex stage
    logic               r_vld_reg;
    logic               r_first_reg;
    logic               r_last_reg;
    logic signed [RW-1:0] rel_x_reg;
    logic signed [RW-1:0] rel_y_reg;
    logic signed [RW-1:0] prev_x_reg;
    logic signed [RW-1:0] prev_y_reg;
    logic signed [CW-1:0] rd_x;
    logic signed [CW-1:0] rd_y;

    // Edge stage
    logic               e_vld_reg;
    logic               e_last_reg;
    logic signed [PW-1:0] prod1_reg;
    logic signed [PW-1:0] prod2_reg;
    logic               straddle_reg;
    logic               xl_pos_reg;
    logic               ep_hit_reg;
    logic               straddle;
    logic               ep_hit;
    logic               xl_pos, xl_neg, xl_zero;
    logic               xr_pos, xr_neg, xr_zero;
    logic               yl_pos, yr_pos;

    // Crossing stage
    logic signed [PW:0] num;
    logic               hit;
    logic               parity_reg;

    assign out_free     = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign inside_res   = out_inside_reg;
    assign vertex_count = out_count_reg;
    assign status       = out_status_reg;

    // Command execution
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_inside_next = out_inside_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        pop             = 1'b0;
        walk_start      = 1'b0;
        we              = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_stat.nonempty && out_free)
                begin
                    pop             = 1'b1;
                    out_valid_next  = 1'b1;
                    out_inside_next = 1'b0;
                    out_status_next = pip_pkg::STAT_OK;
                    case (q_cmd.op)
                        pip_pkg::OP_APPEND:
                        begin
                            if (count_reg == CNT_W'(MAX_VERTICES))
                            begin
                                out_status_next = pip_pkg::STAT_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        pip_pkg::OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                out_status_next = pip_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        pip_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        pip_pkg::OP_QUERY:
                        begin
                            // Empty table or point off the disk answers at once
                            if (!q_cmd.outside && count_reg != '0)
                            begin
                                out_valid_next = 1'b0;
                                walk_start     = 1'b1;
                                state_next     = S_WALK;
                            end
                        end
                        default:
                        begin
                            out_status_next = pip_pkg::STAT_OK;
                        end
                    endcase
                    out_count_next = count_next;
                end
            end
            S_WALK:
            begin
                if (e_vld_reg && e_last_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_inside_next = parity_reg;
                    out_count_next  = count_reg;
                    out_status_next = pip_pkg::STAT_OK;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_inside_reg <= 1'b0;
            out_count_reg  <= '0;
            out_status_reg <= pip_pkg::STAT_OK;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            out_inside_reg <= out_inside_next;
            out_count_reg  <= out_count_next;
            out_status_reg <= out_status_next;
        end
    end

    // Vertex table: x in the upper half, y in the lower half
    assign rd_wrap = rd_idx_reg == count_reg;
    assign raddr   = rd_wrap ? '0 : rd_idx_reg[AW-1:0];
    assign rd_x    = rdata[2*CW-1:CW];
    assign rd_y    = rdata[CW-1:0];

    pip_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_VERTICES)
    ) u_vtx_ram (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({q_cmd.x, q_cmd.y}),
        .re    (issuing_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Edge classification from previous (L) and current (R) vertex
    assign xl_pos  = !prev_x_reg[RW-1] && (prev_x_reg != '0);
    assign xl_neg  = prev_x_reg[RW-1];
    assign xl_zero = prev_x_reg == '0;
    assign xr_pos  = !rel_x_reg[RW-1] && (rel_x_reg != '0);
    assign xr_neg  = rel_x_reg[RW-1];
    assign xr_zero = rel_x_reg == '0;
    assign yl_pos  = !prev_y_reg[RW-1] && (prev_y_reg != '0);
    assign yr_pos  = !rel_y_reg[RW-1] && (rel_y_reg != '0);

    assign straddle = (xl_pos && xr_neg) || (xl_neg && xr_pos);
    assign ep_hit   = (xl_zero && !xr_neg && yl_pos) || (xl_pos && xr_zero && yr_pos);

    // Intercept sign: xl*yr - xr*yl must share the sign of xl - xr
    assign num = $signed({prod1_reg[PW-1], prod1_reg}) - $signed({prod2_reg[PW-1], prod2_reg});
    assign hit = straddle_reg
               ? (xl_pos_reg ? (!num[PW] && num != '0) : num[PW])
               : ep_hit_reg;

    // Walk pipeline valids and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issuing_reg  <= 1'b0;
            rd_idx_reg   <= '0;
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
            r_vld_reg    <= 1'b0;
            r_first_reg  <= 1'b0;
            r_last_reg   <= 1'b0;
            e_vld_reg    <= 1'b0;
            e_last_reg   <= 1'b0;
            parity_reg   <= 1'b0;
        end
        else
        begin
            // Reads run over vertex 0 .. n-1 and then vertex 0 again
            if (walk_start)
            begin
                issuing_reg <= 1'b1;
                rd_idx_reg  <= '0;
            end
            else if (issuing_reg)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
                if (rd_wrap)
                begin
                    issuing_reg <= 1'b0;
                end
            end
            rd_vld_reg   <= issuing_reg;
            rd_first_reg <= issuing_reg && (rd_idx_reg == '0);
            rd_last_reg  <= issuing_reg && rd_wrap;
            r_vld_reg    <= rd_vld_reg;
            r_first_reg  <= rd_first_reg;
            r_last_reg   <= rd_last_reg;
            e_vld_reg    <= r_vld_reg && !r_first_reg;
            e_last_reg   <= r_vld_reg && r_last_reg;
            if (walk_start)
            begin
                parity_reg <= 1'b0;
            end
            else if (e_vld_reg)
            begin
                parity_reg <= parity_reg ^ hit;
            end
        end
    end

    // Walk pipeline payload
    always_ff @(posedge clk)
    begin
        if (walk_start)
        begin
            px_reg <= q_cmd.x;
            py_reg <= q_cmd.y;
        end
        if (rd_vld_reg)
        begin
            rel_x_reg <= $signed({rd_x[CW-1], rd_x}) - $signed({px_reg[CW-1], px_reg});
            rel_y_reg <= $signed({rd_y[CW-1], rd_y}) - $signed({py_reg[CW-1], py_reg});
        end
        if (r_vld_reg)
        begin
            prev_x_reg   <= rel_x_reg;
            prev_y_reg   <= rel_y_reg;
            prod1_reg    <= PW'(prev_x_reg) * PW'(rel_y_reg);
            prod2_reg    <= PW'(rel_x_reg) * PW'(prev_y_reg);
            straddle_reg <= straddle;
            xl_pos_reg   <= xl_pos;
            ep_hit_reg   <= ep_hit;
        end
    end

    `PIP_ASSERT_HOLDS(a_count_bound, count_reg <= CNT_W'(MAX_VERTICES), "vertex count above table size")
    `PIP_ASSERT_IMPLIES(a_no_pop_busy, state_reg != S_IDLE, !pop, "command taken during a query walk")
    `PIP_ASSERT_IMPLIES(a_edge_in_walk, e_vld_reg, state_reg == S_WALK, "edge evaluated outside a walk")

endmodule

`default_nettype wire

### design/point_in_polygon_test.sv
// Top level of the point-in-polygon block: front end, command queue, back end.
// Depends on pip_pkg, pip_front, pip_queue, pip_back (and pip_ram below it).
//
// Keeps a polygon of up to MAX_VERTICES vertices in signed Q1.FRAC_BITS
// coordinates and answers containment queries by crossing-number parity,
// one result beat per input beat, in order. Opcode 0 appends a vertex,
// 1 removes the last one, 2 clears the table, 3 queries the point; a full
// table on append or an empty one on remove leaves the table alone and is
// reported in status. The front end squares the point for the unit-disk
// test in registered stages and feeds a two-entry command queue, so input
// beats keep being taken while the back end is busy or the result waits,
// until the queue fills. Table commands complete at one per cycle while
// the output is not stalled. A query holds the back end for its walk: the
// vertex RAM has one read port and the walk reads one vertex per cycle,
// n + 1 reads for n vertices, then the RAM read and the cross-product and
// parity stages. Off-disk points and empty-table queries answer at once.
`default_nettype none

module point_in_polygon_test #(
    parameter int MAX_VERTICES = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [1:0]                           opcode,
    input  wire logic signed [pip_pkg::COORD_W-1:0]   point_x,
    input  wire logic signed [pip_pkg::COORD_W-1:0]   point_y,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      inside_res,
    output logic [$clog2(MAX_VERTICES+1)-1:0]         vertex_count,
    output logic [1:0]                                status
);

    pip_pkg::q_stat_t  q_stat;
    pip_pkg::cmd_t     push_cmd;
    pip_pkg::cmd_t     head_cmd;
    logic              push;
    logic              pop;

    // Accept and classify
    pip_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .point_x  (point_x),
        .point_y  (point_y),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Decoupling queue
    pip_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    // Execute and answer
    pip_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .q_cmd        (head_cmd),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .inside_res   (inside_res),
        .vertex_count (vertex_count),
        .status       (status)
    );

endmodule

`default_nettype wire
